// ===== design/assert_macros.svh =====
// Assertion helpers for the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define CHECK_ON_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/spk_rld_pkg.sv =====
package spk_rld_pkg;

  // Field widths
  localparam int POS_W  = 21;
  localparam int LEN_W  = 17;
  localparam int BYTE_W = 8;
  localparam int CAP_W  = 25;

  // Largest surface the block addresses
  localparam int unsigned MAX_PIXELS = 1048576;

  // Pixel count after reset
  localparam logic [POS_W-1:0] IMAGE_PIXELS_RESET = 21'd64000;

  // Stream markers
  localparam logic [15:0] MARK_ZERO_RUN = 16'hFFFF;
  localparam logic [15:0] MARK_LITERAL  = 16'hFFFE;
  localparam logic [15:0] MARK_END      = 16'hFFFD;

  typedef enum logic [2:0] {
    PH_MARK_LO,
    PH_MARK_HI,
    PH_CNT_LO,
    PH_CNT_HI,
    PH_LITERAL,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              new_image;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0]  start_index;
    logic [LEN_W-1:0]  run_length;
    logic [BYTE_W-1:0] pixel_value;
    logic              clipped;
    logic              image_end;
  } out_t;

  // Result of one parser step
  typedef struct packed {
    logic valid;
    out_t item;
  } step_res_t;

endpackage

// ===== design/spk_rld_parser.sv =====
module spk_rld_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  spk_rld_pkg::in_t                item,
  input  logic [spk_rld_pkg::POS_W-1:0]   image_pixels,
  output spk_rld_pkg::step_res_t          result
);

  localparam int POS_W = spk_rld_pkg::POS_W;
  localparam int LEN_W = spk_rld_pkg::LEN_W;
  localparam int CAP_W = spk_rld_pkg::CAP_W;
  localparam logic [CAP_W-1:0] CAP = CAP_W'(spk_rld_pkg::MAX_PIXELS);

  spk_rld_pkg::phase_t phase, phase_next, phase_cur;
  logic [7:0]       low_byte_hold, low_byte_hold_next, low_cur;
  logic             literal_mode, literal_mode_next, lit_cur;
  logic [LEN_W-1:0] literal_remaining, literal_remaining_next, rem_cur;
  logic [POS_W-1:0] write_position, write_position_next, pos_cur;

  logic [15:0]      word;
  logic [CAP_W-1:0] lim_wide;
  logic [POS_W-1:0] limit, avail;
  logic [LEN_W-1:0] adv_len, adv_n;
  logic             adv_clip;

  // Apply the new-image clear before the byte is parsed
  always_comb begin
    phase_cur = item.new_image ? spk_rld_pkg::PH_MARK_LO : phase;
    low_cur   = item.new_image ? 8'd0 : low_byte_hold;
    lit_cur   = item.new_image ? 1'b0 : literal_mode;
    rem_cur   = item.new_image ? '0 : literal_remaining;
    pos_cur   = item.new_image ? '0 : write_position;
  end

  assign word = {item.data_byte, low_cur};

  // Clip the run against the effective image size
  always_comb begin
    lim_wide = ({{(CAP_W-POS_W){1'b0}}, image_pixels} > CAP) ? CAP
               : {{(CAP_W-POS_W){1'b0}}, image_pixels};
    limit    = lim_wide[POS_W-1:0];
    avail    = (pos_cur < limit) ? (limit - pos_cur) : '0;
    adv_len  = (phase_cur == spk_rld_pkg::PH_LITERAL) ? LEN_W'(1) : {word, 1'b0};
    if ({{(POS_W-LEN_W){1'b0}}, adv_len} > avail) begin
      adv_n    = avail[LEN_W-1:0];
      adv_clip = 1'b1;
    end else begin
      adv_n    = adv_len;
      adv_clip = 1'b0;
    end
  end

  // Next parser state and result
  always_comb begin
    phase_next             = phase_cur;
    low_byte_hold_next     = low_cur;
    literal_mode_next      = lit_cur;
    literal_remaining_next = rem_cur;
    write_position_next    = pos_cur;
    result                 = '0;
    case (phase_cur)
      spk_rld_pkg::PH_MARK_LO: begin
        low_byte_hold_next = item.data_byte;
        phase_next         = spk_rld_pkg::PH_MARK_HI;
      end
      spk_rld_pkg::PH_MARK_HI: begin
        if (word == spk_rld_pkg::MARK_ZERO_RUN) begin
          literal_mode_next = 1'b0;
          phase_next        = spk_rld_pkg::PH_CNT_LO;
        end else if (word == spk_rld_pkg::MARK_LITERAL) begin
          literal_mode_next = 1'b1;
          phase_next        = spk_rld_pkg::PH_CNT_LO;
        end else if (word == spk_rld_pkg::MARK_END) begin
          phase_next                = spk_rld_pkg::PH_DONE;
          result.valid              = 1'b1;
          result.item.start_index   = pos_cur;
          result.item.image_end     = 1'b1;
        end else begin
          phase_next = spk_rld_pkg::PH_MARK_LO;
        end
      end
      spk_rld_pkg::PH_CNT_LO: begin
        low_byte_hold_next = item.data_byte;
        phase_next         = spk_rld_pkg::PH_CNT_HI;
      end
      spk_rld_pkg::PH_CNT_HI: begin
        if (word == 16'd0) begin
          phase_next = spk_rld_pkg::PH_MARK_LO;
        end else if (lit_cur) begin
          literal_remaining_next = {word, 1'b0};
          phase_next             = spk_rld_pkg::PH_LITERAL;
        end else begin
          phase_next              = spk_rld_pkg::PH_MARK_LO;
          write_position_next     = pos_cur + {{(POS_W-LEN_W){1'b0}}, adv_n};
          result.valid            = 1'b1;
          result.item.start_index = pos_cur;
          result.item.run_length  = adv_n;
          result.item.clipped     = adv_clip;
        end
      end
      spk_rld_pkg::PH_LITERAL: begin
        literal_remaining_next  = rem_cur - LEN_W'(1);
        if (literal_remaining_next == '0) begin
          phase_next = spk_rld_pkg::PH_MARK_LO;
        end
        write_position_next     = pos_cur + {{(POS_W-LEN_W){1'b0}}, adv_n};
        result.valid            = 1'b1;
        result.item.start_index = pos_cur;
        result.item.run_length  = adv_n;
        result.item.pixel_value = item.data_byte;
        result.item.clipped     = adv_clip;
      end
      default: begin
        phase_next = spk_rld_pkg::PH_DONE;
      end
    endcase
  end

  // Advance parser state once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= spk_rld_pkg::PH_MARK_LO;
      low_byte_hold     <= 8'd0;
      literal_mode      <= 1'b0;
      literal_remaining <= '0;
      write_position    <= '0;
    end else if (step) begin
      phase             <= phase_next;
      low_byte_hold     <= low_byte_hold_next;
      literal_mode      <= literal_mode_next;
      literal_remaining <= literal_remaining_next;
      write_position    <= write_position_next;
    end
  end

endmodule

// ===== design/spk_run_length_image_decoder.sv =====
// Run-length palette image decoder. Bytes of the encoded file enter on the
// input channel, one item per byte, and the block accepts one item in every
// clock cycle while in_stall is low. An accepted byte waits in the input
// register, one combinational parser step runs on it, and its result is
// loaded into the result register for the output channel. Zero runs come
// out as one item with their pixel count, literal pixels as one item each,
// and the end marker as an item with image_end set. Runs that pass
// image_pixels (capped at the largest supported surface) are cut short and
// flagged clipped. Write image_pixels only while the block is idle.
module spk_run_length_image_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  spk_rld_pkg::in_t                in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output spk_rld_pkg::out_t               out_item,
  input  logic                            cfg_we,
  input  logic [spk_rld_pkg::POS_W-1:0]   cfg_data
);

  logic                          hold_valid;
  spk_rld_pkg::in_t              hold_item;
  logic [spk_rld_pkg::POS_W-1:0] image_pixels;
  logic                          advance;
  logic                          step;
  spk_rld_pkg::step_res_t        result;

  assign advance  = !out_valid || !out_stall;
  assign step     = hold_valid && advance;
  assign in_stall = hold_valid && !advance;

  // Hold the pixel count register
  always_ff @(posedge clk) begin
    if (rst) begin
      image_pixels <= spk_rld_pkg::IMAGE_PIXELS_RESET;
    end else if (cfg_we) begin
      image_pixels <= cfg_data;
    end
  end

  // Capture the input item
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold_item <= in_item;
    end
  end

  spk_rld_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .item         (hold_item),
    .image_pixels (image_pixels),
    .result       (result)
  );

  // Load the result register when the consumer side is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result.item;
    end
  end

endmodule

// ===== design/spk_rld_checker.sv =====
`include "assert_macros.svh"

module spk_rld_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input spk_rld_pkg::out_t               out_item
);

  logic out_held;
  logic end_item;
  logic end_clean;
  logic bare_item;
  logic pixel_item;

  // Classify the offered result item
  assign out_held   = out_valid && out_stall;
  assign end_item   = out_valid && out_item.image_end;
  assign end_clean  = out_item.run_length == '0 && out_item.pixel_value == '0
                      && !out_item.clipped;
  assign bare_item  = out_valid && !out_item.clipped && !out_item.image_end;
  assign pixel_item = out_valid && out_item.pixel_value != '0;

  // A stalled result item holds
  `CHECK_ON_CLK(a_out_hold, out_held |=> out_valid && $stable(out_item), "stalled result changed")

  // The end item carries no pixels
  `CHECK_ON_CLK(a_end_empty, end_item |-> end_clean, "end item carries pixels")

  // Unclipped pixel items always write something, nonzero-valued items at most one pixel
  `CHECK_ON_CLK(a_len_nonzero, bare_item |-> out_item.run_length != '0, "unclipped item empty")
  `CHECK_ON_CLK(a_literal_one, pixel_item |-> out_item.run_length <= 1, "colored run too long")

  // Nothing is offered right after reset
  `CHECK_ALWAYS(a_reset_idle, rst |=> !out_valid, "result offered after reset")

endmodule

bind spk_run_length_image_decoder spk_rld_checker u_spk_rld_checker (.*);
